// ===== hw/rtl/gauss_seidel_poisson_sweep_unit_macros.svh =====
// Assertion macros for the sweep unit.
`ifndef GAUSS_SEIDEL_POISSON_SWEEP_UNIT_MACROS_SVH
`define GAUSS_SEIDEL_POISSON_SWEEP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GSP_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GSP_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define GSP_ASSERT_IMPL(label, clk, rst, prop, msg)
`define GSP_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

// ===== hw/rtl/gsp_pkg.sv =====
`timescale 1ns / 1ps
package gsp_pkg;
  localparam int MAX_WIDTH_LOG2 = 6;
  localparam int NODE_DEPTH = 4225;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SWEEP = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] REG_WIDTH_LOG2 = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
  localparam logic [1:0] REG_STEP_X     = 2'd2;
  localparam logic [1:0] REG_STEP_Y     = 2'd3;
  localparam int QUOT_BITS = 128;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_op;    // latch a new item
    logic mem_write;  // host write into the stores
    logic mem_read;   // host read from the value store
    logic sw_init;    // reset sweep position
    logic fetch;      // issue neighbor reads for current node
    logic mul_start;  // begin products
    logic div_start;  // begin division
    logic wb;         // write result back
    logic advance;    // next node
    logic result;     // present result
  } gsp_cmd_t;

  typedef struct packed {
    logic index_bad;
    logic sweep_skip;
    logic last_node;
    logic mul_done;
    logic div_done;
  } gsp_status_t;
endpackage

// ===== hw/rtl/gsp_ram.sv =====
`timescale 1ns / 1ps
module gsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4225
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/gsp_ctrl.sv =====
`timescale 1ns / 1ps
module gsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          opcode,
  input  gsp_pkg::gsp_status_t st,
  output gsp_pkg::gsp_cmd_t   cmd,
  output logic                busy
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_FET  = 4'd3;
  localparam logic [3:0] S_FW   = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WB   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_SINI = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] op, op_next;
  logic [2:0] fcnt, fcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= gsp_pkg::OP_WRITE;
      fcnt <= '0;
    end else begin
      state <= state_next;
      op <= op_next;
      fcnt <= fcnt_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    op_next = op;
    fcnt_next = fcnt;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_op = 1'b1;
          op_next = opcode;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (op == gsp_pkg::OP_SWEEP) begin
          cmd.sw_init = 1'b1;
          state_next = S_SINI;
        end else if (op == gsp_pkg::OP_WRITE && !st.index_bad) begin
          cmd.mem_write = 1'b1;
          state_next = S_DONE;
        end else if (op == gsp_pkg::OP_READ && !st.index_bad) begin
          cmd.mem_read = 1'b1;
          state_next = S_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RD: state_next = S_DONE;
      S_SINI: state_next = st.sweep_skip ? S_DONE : S_FET;
      S_FET: begin
        // Five reads (left, right, up, down, source) one per cycle.
        cmd.fetch = 1'b1;
        fcnt_next = fcnt + 3'd1;
        if (fcnt == 3'd4) begin
          fcnt_next = '0;
          state_next = S_FW;
        end
      end
      S_FW: begin
        cmd.mul_start = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (st.mul_done) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.wb = 1'b1;
        cmd.advance = 1'b1;
        state_next = st.last_node ? S_DONE : S_FET;
      end
      S_DONE: begin
        cmd.result = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/gsp_datapath.sv =====
`timescale 1ns / 1ps
module gsp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  gsp_pkg::gsp_cmd_t   cmd,
  output gsp_pkg::gsp_status_t st,
  input  logic [2:0]          width_log2,
  input  logic [6:0]          row_count,
  input  logic [15:0]         step_x,
  input  logic [15:0]         step_y,
  input  logic [1:0]          opcode,
  input  logic [12:0]         node_index,
  input  logic signed [31:0]  node_value,
  input  logic signed [31:0]  node_source,
  output logic signed [31:0]  read_value,
  output logic                status,
  output logic                done
);
  localparam int AW = $clog2(gsp_pkg::NODE_DEPTH);
  localparam int CW = AW + 2;
  localparam int WW = gsp_pkg::MAX_WIDTH_LOG2 + 2;
  localparam int QB = gsp_pkg::QUOT_BITS;

  logic [1:0]         op;
  logic [12:0]        idx;
  logic signed [31:0] val_in, src_in;
  logic [2:0]         e_sat;
  logic [WW-1:0]      w;
  logic [CW-1:0]      rows_lim, rows, count;
  logic [CW-1:0]      rows_tab [8];

  always_comb begin
    e_sat = width_log2;
    if (e_sat < 3'd1) e_sat = 3'd1;
    if (32'(e_sat) > gsp_pkg::MAX_WIDTH_LOG2) e_sat = 3'(gsp_pkg::MAX_WIDTH_LOG2);
  end
  assign w = (WW'(1) << e_sat) + WW'(1);

  // Rows that fit: NODE_DEPTH / w, from a small per-exponent table.
  genvar g;
  for (g = 0; g < 8; g++) begin : g_rows_tab
    localparam int LIM = gsp_pkg::NODE_DEPTH / ((1 << g) + 1);
    assign rows_tab[g] = CW'(LIM);
  end
  assign rows_lim = rows_tab[e_sat];
  assign rows = (CW'(row_count) < rows_lim) ? CW'(row_count) : rows_lim;

  logic [2*CW-1:0] count_full;
  always_ff @(posedge clk) begin
    count_full <= rows * CW'(w);
  end
  assign count = count_full[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op <= opcode;
      idx <= node_index;
      val_in <= node_value;
      src_in <= node_source;
    end
  end
  assign st.index_bad = (CW'(idx) >= count);

  // Sweep position.
  logic [CW-1:0] r, c, cur;
  logic [2:0]    fcnt;
  logic [AW-1:0] raddr;
  logic [31:0]   vq, sq;
  logic signed [31:0] nb_l, nb_r, nb_u, nb_d, nb_s;
  logic [2:0]    cap;
  logic          cap_v;

  assign st.last_node = (c + CW'(2) >= CW'(w)) && (r + CW'(2) >= rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= '0;
      cap_v <= 1'b0;
    end else begin
      cap_v <= cmd.fetch;
      cap <= fcnt;
      if (cmd.fetch) fcnt <= (fcnt == 3'd4) ? 3'd0 : fcnt + 3'd1;
    end
    if (cmd.sw_init) begin
      r <= CW'(1);
      c <= CW'(1);
      cur <= CW'(w) + CW'(1);
    end else if (cmd.advance) begin
      if (c + CW'(2) >= CW'(w)) begin
        c <= CW'(1);
        r <= r + CW'(1);
        cur <= cur + CW'(3);
      end else begin
        c <= c + CW'(1);
        cur <= cur + CW'(1);
      end
    end
    if (cap_v) begin
      case (cap)
        3'd0: nb_l <= vq;
        3'd1: nb_r <= vq;
        3'd2: nb_u <= vq;
        3'd3: nb_d <= vq;
        default: nb_s <= sq;
      endcase
    end
  end

  always_comb begin
    raddr = idx[AW-1:0];
    if (cmd.fetch) begin
      case (fcnt)
        3'd0: raddr = AW'(cur - CW'(1));
        3'd1: raddr = AW'(cur + CW'(1));
        3'd2: raddr = AW'(cur - CW'(w));
        3'd3: raddr = AW'(cur + CW'(w));
        default: raddr = AW'(cur);
      endcase
    end
  end

  // Products: a=dx^2, b=dy^2 (Q8.24), one multiply per cycle.
  logic [31:0] a, b;
  logic [63:0] ab;
  logic signed [32:0] lr, ud;
  logic [32:0] m1, m2;
  logic [31:0] m3;
  logic n1, n2, n3;
  logic [3:0] mstep;
  logic mbusy;
  logic mdone;
  logic [64:0] p1, p2;
  logic [95:0] p3;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic [63:0] ab_lo_acc;

  assign lr = 33'(nb_l) + 33'(nb_r);
  assign ud = 33'(nb_u) + 33'(nb_d);

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (mstep)
      4'd0: begin mul_x = 32'(step_x); mul_y = 32'(step_x); end
      4'd1: begin mul_x = 32'(step_y); mul_y = 32'(step_y); end
      4'd2: begin mul_x = a; mul_y = b; end
      4'd3: begin mul_x = b; mul_y = m1[31:0]; end
      4'd4: begin mul_x = a; mul_y = m2[31:0]; end
      4'd5: begin mul_x = ab[31:0]; mul_y = m3; end
      4'd6: begin mul_x = ab[63:32]; mul_y = m3; end
      default: ;
    endcase
  end
  assign mul_p = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mstep <= '0;
      mdone <= 1'b0;
    end else begin
      mdone <= mbusy && (mstep == 4'd6);
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mstep <= '0;
      end else if (mbusy) begin
        mstep <= mstep + 4'd1;
        case (mstep)
          4'd0: begin
            a <= mul_p[31:0];
            // The source word reaches nb_s only through the store's read register and the
            // capture register, so the magnitudes are taken here rather than at the start command.
            n1 <= lr[32];
            n2 <= ud[32];
            n3 <= nb_s[31];
            m1 <= lr[32] ? 33'(-lr) : 33'(lr);
            m2 <= ud[32] ? 33'(-ud) : 33'(ud);
            m3 <= nb_s[31] ? 32'(-nb_s) : 32'(nb_s);
          end
          4'd1: b <= mul_p[31:0];
          4'd2: ab <= mul_p;
          // m1 top bit contributes b<<32.
          4'd3: p1 <= 65'(mul_p) + (m1[32] ? {1'b0, b, 32'd0} : 65'd0);
          4'd4: p2 <= 65'(mul_p) + (m2[32] ? {1'b0, a, 32'd0} : 65'd0);
          4'd5: ab_lo_acc <= mul_p;
          4'd6: begin
            p3 <= 96'(ab_lo_acc) + {mul_p, 32'd0};
            mbusy <= 1'b0;
          end
          default: mbusy <= 1'b0;
        endcase
      end
    end
  end
  assign st.mul_done = mdone;

  // Numerator and restoring division, one quotient bit per cycle.
  logic [QB-1:0] t1, t2, t3, num;
  logic [QB-1:0] dq, qv;
  logic [QB:0]   rem;
  logic [QB-1:0] div_d;
  logic [7:0]    dcnt;
  logic          dbusy, dneg, dzero;
  logic [QB:0]   rem_sh;
  logic [31:0]   res;

  always_comb begin
    t1 = QB'(p1) << 24;
    t2 = QB'(p2) << 24;
    t3 = QB'(p3);
    if (n1) t1 = -t1;
    if (n2) t2 = -t2;
    if (!n3) t3 = -t3;
  end
  assign num = t1 + t2 + t3;
  assign rem_sh = {rem[QB-1:0], dq[QB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dneg <= num[QB-1];
      dq <= num[QB-1] ? -num : num;
      div_d <= QB'({32'd0, 1'b0} + 33'(a) + 33'(b)) << 25;
      dzero <= (a == 32'd0) && (b == 32'd0);
      rem <= '0;
      qv <= '0;
      dcnt <= '0;
      dbusy <= 1'b1;
    end else if (dbusy) begin
      dq <= dq << 1;
      if (rem_sh >= {1'b0, div_d}) begin
        rem <= rem_sh - {1'b0, div_d};
        qv <= {qv[QB-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        qv <= {qv[QB-2:0], 1'b0};
      end
      dcnt <= dcnt + 8'd1;
      if (dcnt == 8'(QB - 1)) dbusy <= 1'b0;
    end
  end
  assign st.div_done = !dbusy && !cmd.div_start;

  always_comb begin
    if (dneg) begin
      if (qv[QB-1:32] != '0 || qv[31:0] > 32'h8000_0000) res = 32'h8000_0000;
      else res = -qv[31:0];
    end else begin
      if (qv[QB-1:31] != '0) res = 32'h7FFF_FFFF;
      else res = qv[31:0];
    end
  end

  // Zero divisor or too few rows: sweep does nothing.
  assign st.sweep_skip = (rows < CW'(3)) ||
                         ((step_x == 16'd0) && (step_y == 16'd0));

  logic          v_we;
  logic [AW-1:0] v_wa;
  logic [31:0]   v_wd;
  assign v_we = cmd.mem_write || (cmd.wb && !dzero);
  assign v_wa = cmd.wb ? AW'(cur) : idx[AW-1:0];
  assign v_wd = cmd.wb ? res : val_in;

  gsp_ram #(.WIDTH(32), .DEPTH(gsp_pkg::NODE_DEPTH)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(raddr), .rdata(vq)
  );
  gsp_ram #(.WIDTH(32), .DEPTH(gsp_pkg::NODE_DEPTH)) u_src (
    .clk(clk), .we(cmd.mem_write), .waddr(idx[AW-1:0]), .wdata(src_in),
    .raddr(raddr), .rdata(sq)
  );

  logic rd_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done <= cmd.result;
      if (cmd.mem_read) rd_pend <= 1'b1;
      else if (cmd.result) rd_pend <= 1'b0;
    end
    if (cmd.result) begin
      read_value <= rd_pend ? vq : 32'd0;
      status <= (op == gsp_pkg::OP_WRITE || op == gsp_pkg::OP_READ) && st.index_bad;
    end
  end
endmodule

// ===== hw/rtl/gauss_seidel_poisson_sweep_unit.sv =====
// A write, an out-of-range index or an unused opcode is answered from the decode state through
// the done state, a good read through an extra read state; results cannot be stalled.
// A sweep passes the decode and sweep-init states, then per interior node five reads, a setup state,
// products on the shared 32x32 multiplier, the bit-serial divider and the write-back, then the done state.
// busy drops in the cycle of the done strobe, so the next item can be taken at its end.
// Synchronous reset restores control and configuration defaults; grid stores are not cleared.
`timescale 1ns / 1ps
`include "gauss_seidel_poisson_sweep_unit_macros.svh"
module gauss_seidel_poisson_sweep_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [12:0]        node_index,
  input  logic signed [31:0] node_value,
  input  logic signed [31:0] node_source,
  output logic signed [31:0] read_value,
  output logic               status,
  output logic               done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  logic [2:0]  width_log2;
  logic [6:0]  row_count;
  logic [15:0] step_x, step_y;
  gsp_pkg::gsp_cmd_t    cmd;
  gsp_pkg::gsp_status_t st;
  logic [2:0]  store_cmds;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2 <= 3'd6;
      row_count <= 7'd65;
      step_x <= 16'd4096;
      step_y <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gsp_pkg::REG_WIDTH_LOG2: width_log2 <= cfg_data[2:0];
        gsp_pkg::REG_ROW_COUNT:  row_count <= cfg_data[6:0];
        gsp_pkg::REG_STEP_X:     step_x <= cfg_data;
        gsp_pkg::REG_STEP_Y:     step_y <= cfg_data;
        default: ;
      endcase
    end
  end

  gsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .st(st), .cmd(cmd),
    .busy(busy)
  );

  gsp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .width_log2(width_log2),
    .row_count(row_count), .step_x(step_x), .step_y(step_y), .opcode(opcode),
    .node_index(node_index), .node_value(node_value), .node_source(node_source),
    .read_value(read_value), .status(status), .done(done)
  );

  assign store_cmds = {cmd.mem_write, cmd.wb, cmd.load_op};

  `GSP_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted item must raise busy")
  `GSP_ASSERT_IMPL(a_done_idle, clk, rst, done |-> !busy, "result while still busy")
  `GSP_ASSERT_IMPL(a_one_cmd, clk, rst, $onehot0(store_cmds), "conflicting store writes")
endmodule
